// File: rtl/salpm_pkg.sv
// ----------------------------------------------------------------------------
// salpm_pkg: shared types and constants for the axis limit / probe model
// Transfer structs, register indexes, function codes and field widths.
// ----------------------------------------------------------------------------
package salpm_pkg;

   // geometry
   localparam int NUM_AXES_MAX = 3;
   localparam int AXES_DEFAULT = 3;
   localparam int Z_AXIS       = 2;
   localparam int POS_W        = 32;
   localparam int STEPS_W      = 30;
   localparam int MASK_W       = 6;

   // configuration port
   localparam int NUM_REGS   = 8;
   localparam int CSR_IDX_W  = $clog2(NUM_REGS);
   localparam int CSR_DATA_W = STEPS_W;

   localparam logic [CSR_IDX_W-1:0] REG_AXIS_MASKS  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_TRAVEL_X    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_TRAVEL_Y    = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_TRAVEL_Z    = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_SEEK_X      = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_SEEK_Y      = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_SEEK_Z      = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_PROBE_TRIP  = CSR_IDX_W'(7);

   // request function codes
   localparam logic [1:0] FUNC_STEP  = 2'd0;
   localparam logic [1:0] FUNC_PROBE = 2'd1;
   localparam logic [1:0] FUNC_PARK  = 2'd2;

   typedef struct packed {
      logic [1:0] func;
      logic [2:0] step_mask;
      logic [2:0] dir_bits;
      logic       probing;
   } req_type;

   typedef struct packed {
      logic [2:0] limit_pins;
      logic       probe_tripped;
      logic       probe_armed;
   } rsp_type;

   // register file contents seen by the datapath
   typedef struct packed {
      logic [NUM_AXES_MAX-1:0]              homes_neg;
      logic [NUM_AXES_MAX-1:0]              pin_invert;
      logic [NUM_AXES_MAX-1:0][STEPS_W-1:0] travel;
      logic [NUM_AXES_MAX-1:0][STEPS_W-1:0] seek_offset;
      logic [STEPS_W-1:0]                   probe_trip;
   } csr_type;

   // per-axis controls for one transfer
   typedef struct packed {
      logic step;
      logic dir;
      logic park;
   } axis_ctl_type;

   // probe controls for one transfer
   typedef struct packed {
      logic eval;
      logic configure;
      logic probing;
   } probe_ctl_type;

endpackage

// File: rtl/salpm_csr.sv
// ----------------------------------------------------------------------------
// salpm_csr: configuration register file
// Write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module salpm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [salpm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [salpm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output salpm_pkg::csr_type                  regs
);

   salpm_pkg::csr_type regs_ff;
   salpm_pkg::csr_type regs_in;

   // register decode
   always_comb begin
      regs_in = regs_ff;
      if (csr_wen) begin
         unique case (csr_index)
            salpm_pkg::REG_AXIS_MASKS: begin
               regs_in.homes_neg  = csr_wdata[2:0];
               regs_in.pin_invert = csr_wdata[5:3];
            end
            salpm_pkg::REG_TRAVEL_X:   regs_in.travel[0]      = csr_wdata;
            salpm_pkg::REG_TRAVEL_Y:   regs_in.travel[1]      = csr_wdata;
            salpm_pkg::REG_TRAVEL_Z:   regs_in.travel[2]      = csr_wdata;
            salpm_pkg::REG_SEEK_X:     regs_in.seek_offset[0] = csr_wdata;
            salpm_pkg::REG_SEEK_Y:     regs_in.seek_offset[1] = csr_wdata;
            salpm_pkg::REG_SEEK_Z:     regs_in.seek_offset[2] = csr_wdata;
            salpm_pkg::REG_PROBE_TRIP: regs_in.probe_trip     = csr_wdata;
            default:                   regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

// File: rtl/salpm_axis.sv
// ----------------------------------------------------------------------------
// salpm_axis: one axis position counter
// Step by one, park near the homing switch, and evaluate the limit trip.
// ----------------------------------------------------------------------------
module salpm_axis (
   input  logic                              clock,
   input  logic                              reset,
   input  salpm_pkg::axis_ctl_type           ctl,
   input  logic                              homes_neg,
   input  logic [salpm_pkg::STEPS_W-1:0]     travel,
   input  logic [salpm_pkg::STEPS_W-1:0]     seek_offset,
   output logic [salpm_pkg::POS_W-1:0]       pos_cur,
   output logic [salpm_pkg::POS_W-1:0]       pos_next,
   output logic                              trip_next
);

   localparam int PW = salpm_pkg::POS_W;
   localparam int SW = salpm_pkg::STEPS_W;

   logic [PW-1:0]        pos_ff;
   logic [PW-1:0]        pos_in;
   logic [PW-1:0]        pos_step;
   logic                 travel_on;
   logic [SW-1:0]        offset_eff;
   logic [SW-1:0]        park_mag;
   logic signed [PW-1:0] park_pos;
   logic signed [PW-1:0] park_neg;
   logic signed [PW-1:0] travel_pos;
   logic signed [PW-1:0] travel_neg;
   logic                 park_move;

   assign travel_on = (travel != '0);

   // single step
   assign pos_step = ctl.dir ? (pos_ff - PW'(1)) : (pos_ff + PW'(1));

   // park spot: travel minus offset, offset falls back to half the travel
   assign offset_eff = (seek_offset >= travel) ? (travel >> 1) : seek_offset;
   assign park_mag   = travel - offset_eff;
   assign park_pos   = $signed({{(PW-SW){1'b0}}, park_mag});
   assign park_neg   = -park_pos;

   always_comb begin
      if (homes_neg) begin
         park_move = travel_on && ($signed(pos_ff) > park_neg);
      end else begin
         park_move = travel_on && ($signed(pos_ff) < park_pos);
      end
   end

   // next position
   always_comb begin
      if (ctl.step) begin
         pos_in = pos_step;
      end else if (ctl.park && park_move) begin
         pos_in = homes_neg ? park_neg : park_pos;
      end else begin
         pos_in = pos_ff;
      end
   end

   // limit trip on the updated position
   assign travel_pos = $signed({{(PW-SW){1'b0}}, travel});
   assign travel_neg = -travel_pos;

   always_comb begin
      if (homes_neg) begin
         trip_next = travel_on && ($signed(pos_in) <= travel_neg);
      end else begin
         trip_next = travel_on && ($signed(pos_in) >= travel_pos);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   assign pos_cur  = pos_ff;
   assign pos_next = pos_in;

endmodule

// File: rtl/salpm_probe.sv
// ----------------------------------------------------------------------------
// salpm_probe: probe arm state and trip detector
// Captures Z at arming and trips once Z has moved the trip distance.
// ----------------------------------------------------------------------------
module salpm_probe (
   input  logic                              clock,
   input  logic                              reset,
   input  salpm_pkg::probe_ctl_type          ctl,
   input  logic [salpm_pkg::POS_W-1:0]       z_cur,
   input  logic [salpm_pkg::POS_W-1:0]       z_next,
   input  logic [salpm_pkg::STEPS_W-1:0]     trip_steps,
   output logic                              armed_next,
   output logic                              trip_next
);

   localparam int PW = salpm_pkg::POS_W;
   localparam int SW = salpm_pkg::STEPS_W;

   logic          armed_ff;
   logic          armed_in;
   logic          trip_ff;
   logic          trip_in;
   logic [PW-1:0] start_ff;
   logic [PW-1:0] start_in;
   logic [PW-1:0] diff;
   logic [PW-1:0] z_dist;

   // distance from the arming point, magnitude taken modulo 2^32
   assign diff   = z_next - start_ff;
   assign z_dist = diff[PW-1] ? (PW'(0) - diff) : diff;

   always_comb begin
      armed_in = armed_ff;
      trip_in  = trip_ff;
      start_in = start_ff;
      if (ctl.configure) begin
         if (ctl.probing) begin
            // arming again keeps the first capture
            if (!armed_ff) begin
               start_in = z_cur;
               armed_in = 1'b1;
            end
         end else begin
            armed_in = 1'b0;
            trip_in  = 1'b0;
         end
      end else if (ctl.eval && armed_ff) begin
         trip_in = (z_dist >= {{(PW-SW){1'b0}}, trip_steps});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         trip_ff  <= 1'b0;
         start_ff <= '0;
      end else begin
         armed_ff <= armed_in;
         trip_ff  <= trip_in;
         start_ff <= start_in;
      end
   end

   assign armed_next = armed_in;
   assign trip_next  = trip_in;

endmodule

// File: rtl/stepper_axis_limit_probe_model.sv
// ----------------------------------------------------------------------------
// stepper_axis_limit_probe_model: three-axis step/dir model with limits, probe
// Tracks signed step counts per axis, drives limit pin levels and probe state.
// ----------------------------------------------------------------------------
//
//   channel   direction  ports                            payload
//   req       in         req_valid, req_ready, req_payload  func, step/dir masks, probing
//   rsp       out        rsp_valid, rsp_ready, rsp_payload  limit pins, probe tripped/armed
//   csr       in         csr_wen, csr_index, csr_wdata      one register per write
//
// One request is taken per cycle unless the response stalls; its response is
// registered through the input register, then the result register, after the
// request transfer. All state updates happen in one pass from the input
// register, so sustained rate is one item per cycle while the response is
// not stalled. A stalled response holds the result register and, one item
// later, the input register; req_ready drops only when both are full.
// Synchronous reset clears positions, probe state, pins and registers.
//
module stepper_axis_limit_probe_model #(
   parameter int AXES = salpm_pkg::AXES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  salpm_pkg::req_type                req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output salpm_pkg::rsp_type                rsp_payload,
   input  logic                              csr_wen,
   input  logic [salpm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [salpm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int NA = salpm_pkg::NUM_AXES_MAX;
   localparam int PW = salpm_pkg::POS_W;

   salpm_pkg::csr_type       regs;
   salpm_pkg::req_type       in_ff;
   logic                     in_valid_ff;
   salpm_pkg::rsp_type       rsp_ff;
   salpm_pkg::rsp_type       rsp_in;
   logic                     rsp_valid_ff;
   logic [NA-1:0]            limit_ff;
   logic [NA-1:0]            limit_in;
   logic                     advance;
   logic                     is_step;
   logic                     is_probe;
   logic                     is_park;
   logic                     eval;
   logic [NA-1:0][PW-1:0]    pos_cur;
   logic [NA-1:0][PW-1:0]    pos_next;
   logic [NA-1:0]            trip_next;
   salpm_pkg::probe_ctl_type probe_ctl;
   logic                     probe_armed;
   logic                     probe_trip;

   salpm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .regs      (regs)
   );

   // handshake: input register feeds result register
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
   end

   // function decode
   always_comb begin
      is_step  = 1'b0;
      is_probe = 1'b0;
      is_park  = 1'b0;
      unique case (in_ff.func)
         salpm_pkg::FUNC_STEP:  is_step  = advance;
         salpm_pkg::FUNC_PROBE: is_probe = advance;
         salpm_pkg::FUNC_PARK:  is_park  = advance;
         default: begin
            is_step  = 1'b0;
            is_probe = 1'b0;
            is_park  = 1'b0;
         end
      endcase
   end

   // pins and probe are re-evaluated only on a step with some pulse
   assign eval = is_step && (in_ff.step_mask != '0);

   // axis counters; missing axes read as zero
   for (genvar i = 0; i < NA; i++) begin : g_axis
      if (i < AXES) begin : g_on
         salpm_pkg::axis_ctl_type ctl;
         assign ctl.step = is_step && in_ff.step_mask[i];
         assign ctl.dir  = in_ff.dir_bits[i];
         assign ctl.park = is_park;

         salpm_axis u_axis (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .homes_neg   (regs.homes_neg[i]),
            .travel      (regs.travel[i]),
            .seek_offset (regs.seek_offset[i]),
            .pos_cur     (pos_cur[i]),
            .pos_next    (pos_next[i]),
            .trip_next   (trip_next[i])
         );
      end else begin : g_off
         assign pos_cur[i]   = '0;
         assign pos_next[i]  = '0;
         assign trip_next[i] = 1'b0;
      end
   end

   // probe watches Z
   assign probe_ctl.eval      = eval;
   assign probe_ctl.configure = is_probe;
   assign probe_ctl.probing   = in_ff.probing;

   salpm_probe u_probe (
      .clock      (clock),
      .reset      (reset),
      .ctl        (probe_ctl),
      .z_cur      (pos_cur[salpm_pkg::Z_AXIS]),
      .z_next     (pos_next[salpm_pkg::Z_AXIS]),
      .trip_steps (regs.probe_trip),
      .armed_next (probe_armed),
      .trip_next  (probe_trip)
   );

   // limit pin levels, pre-inverted
   assign limit_in = eval ? (trip_next ^ regs.pin_invert) : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // result register
   always_comb begin
      rsp_in.limit_pins    = limit_in;
      rsp_in.probe_tripped = probe_trip;
      rsp_in.probe_armed   = probe_armed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
